// ===== sv/lwfd_pkg.sv =====
// shared widths, defaults and reset values for the longest-window block
package lwfd_pkg;

  localparam int unsigned     MAX_KINDS_DEF = 4;
  localparam longint unsigned SEQ_MAX_DEF   = 64'd65536;

  localparam int VAL_W     = 32;
  localparam int LEN_W     = 17;
  localparam int CFG_W     = 3;
  localparam int OUT_DAT_W = 40;

  localparam logic [CFG_W-1:0] KINDS_RESET = 3'd2;

endpackage

// ===== sv/longest_window_few_distinct.sv =====
// longest run of consecutive items holding at most kinds_allowed distinct values
// a beat accepted into the input stage is registered into the result stage once that is free
// throughput: one beat per cycle while m_tready holds; combinational lookup, registered update
// the table of kinds and the window counters live in registers updated once per item
// rst (synchronous, active high) clears the sequence state, both stages and sets
// kinds_allowed back to 2; the table contents are not cleared, only their used bits
module longest_window_few_distinct
  import lwfd_pkg::*;
#(
  parameter int unsigned     MAX_KINDS = MAX_KINDS_DEF,
  parameter longint unsigned SEQ_MAX   = SEQ_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     cfg_data,      // kinds_allowed
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [VAL_W-1:0]     s_tdata,       // [31:0] item_value
  input  logic                 s_tlast,       // seq_end
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_DAT_W-1:0] m_tdata,       // [16:0] best_length, [33:17] window_length, rest zero
  output logic                 m_tlast,       // final_result
  output logic                 m_tuser        // overflow
);

  // positions run 0..SEQ_MAX-1; the item counter must also hold SEQ_MAX itself
  localparam int POS_W = $clog2(SEQ_MAX);
  localparam int CNT_W = $clog2(MAX_KINDS + 1);
  localparam int IDX_W = (MAX_KINDS > 1) ? $clog2(MAX_KINDS) : 1;
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [POS_W:0] SEQ_MAX_P  = (POS_W + 1)'(SEQ_MAX);
  localparam logic [POS_W:0] LAST_POS_P = (POS_W + 1)'(SEQ_MAX - 1);

  // configuration register
  logic [CFG_W-1:0] kinds_allowed;

  // kind table: values and positions written only on use, used bits reset
  logic [VAL_W-1:0]   kind_value    [MAX_KINDS];
  logic [POS_W-1:0]   kind_last_pos [MAX_KINDS];
  logic [MAX_KINDS-1:0] kind_used, kind_used_next;

  // sequence counters
  logic [POS_W-1:0] window_start, window_start_next;
  logic [POS_W:0]   position, position_next;
  logic [POS_W:0]   best_so_far, best_so_far_next;
  logic             overflow_seen, overflow_seen_next;

  // input stage
  logic             in_valid;
  logic [VAL_W-1:0] in_value;
  logic             in_last;

  // result stage
  logic             out_valid;
  logic [POS_W:0]   out_best;
  logic [POS_W:0]   out_wlen;
  logic             out_last;
  logic             out_ovf;

  logic advance;

  // table write port for this item
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_idx;

  // lookup results
  logic             hit_found, free_found, old_found, room;
  logic [IDX_W-1:0] hit_idx, free_idx, old_idx;
  logic [POS_W-1:0] old_pos;
  logic [CNT_W-1:0] used_cnt;
  logic [POS_W:0]   cur, new_start, ws_ext, wlen;
  logic [CMP_W-1:0] limit;

  // input stage frees itself whenever its beat moves into the result stage
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kinds_allowed <= KINDS_RESET;
    end else if (cfg_valid) begin
      kinds_allowed <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_value <= s_tdata;
      in_last  <= s_tlast;
    end
  end

  // lookup, allocation or eviction, and window update for the item in the input stage
  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    free_found = 1'b0;
    free_idx   = '0;
    used_cnt   = '0;
    old_found  = 1'b0;
    old_idx    = '0;
    old_pos    = '0;
    tbl_we     = 1'b0;
    tbl_idx    = '0;
    new_start  = '0;

    kind_used_next     = kind_used;
    position_next      = position;
    overflow_seen_next = overflow_seen;

    // past the position range the item sits on the last position
    if (position < SEQ_MAX_P) begin
      cur           = position;
      position_next = position + (POS_W + 1)'(1);
    end else begin
      cur                = LAST_POS_P;
      overflow_seen_next = 1'b1;
    end

    for (int i = 0; i < MAX_KINDS; i++) begin
      if (kind_used[i]) begin
        used_cnt = used_cnt + CNT_W'(1);
        if (!hit_found && kind_value[i] == in_value) begin
          hit_found = 1'b1;
          hit_idx   = IDX_W'(i);
        end
      end else if (!free_found) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end

    // oldest entry, lowest index on ties
    for (int i = 0; i < MAX_KINDS; i++) begin
      if (kind_used[i] && (!old_found || kind_last_pos[i] < old_pos)) begin
        old_found = 1'b1;
        old_idx   = IDX_W'(i);
        old_pos   = kind_last_pos[i];
      end
    end

    // a limit of zero behaves as one
    limit = (kinds_allowed == '0) ? CMP_W'(1) : CMP_W'(kinds_allowed);
    room  = free_found && (CMP_W'(used_cnt) < limit);

    ws_ext = {1'b0, window_start};
    if (hit_found) begin
      tbl_we  = 1'b1;
      tbl_idx = hit_idx;
    end else if (room) begin
      tbl_we  = 1'b1;
      tbl_idx = free_idx;
      kind_used_next[free_idx] = 1'b1;
    end else if (old_found) begin
      tbl_we    = 1'b1;
      tbl_idx   = old_idx;
      new_start = {1'b0, old_pos} + (POS_W + 1)'(1);
      if (new_start > ws_ext) begin
        ws_ext = new_start;
      end
    end

    // window never starts past the current item
    if (ws_ext > cur) begin
      ws_ext = cur;
    end
    window_start_next = ws_ext[POS_W-1:0];
    wlen              = cur - ws_ext + (POS_W + 1)'(1);
    best_so_far_next  = (wlen > best_so_far) ? wlen : best_so_far;
  end

  // table payload, no reset
  always_ff @(posedge clk) begin
    if (advance && tbl_we) begin
      kind_value[tbl_idx]    <= in_value;
      kind_last_pos[tbl_idx] <= cur[POS_W-1:0];
    end
  end

  // sequence state; the final item of a sequence returns it to reset
  always_ff @(posedge clk) begin
    if (rst) begin
      kind_used     <= '0;
      window_start  <= '0;
      position      <= '0;
      best_so_far   <= (POS_W + 1)'(1);
      overflow_seen <= 1'b0;
    end else if (advance) begin
      if (in_last) begin
        kind_used     <= '0;
        window_start  <= '0;
        position      <= '0;
        best_so_far   <= (POS_W + 1)'(1);
        overflow_seen <= 1'b0;
      end else begin
        kind_used     <= kind_used_next;
        window_start  <= window_start_next;
        position      <= position_next;
        best_so_far   <= best_so_far_next;
        overflow_seen <= overflow_seen_next;
      end
    end
  end

  // result stage holds its beat until the master side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_best <= best_so_far_next;
      out_wlen <= wlen;
      out_last <= in_last;
      out_ovf  <= overflow_seen_next;
    end
  end

  // lengths leave as LEN_W-bit fields whatever the position width
  logic [POS_W+LEN_W:0] best_wide, wlen_wide;
  assign best_wide = (POS_W + LEN_W + 1)'(out_best);
  assign wlen_wide = (POS_W + LEN_W + 1)'(out_wlen);

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_DAT_W - 2 * LEN_W)'(0), wlen_wide[LEN_W-1:0], best_wide[LEN_W-1:0]};
  assign m_tlast  = out_last;
  assign m_tuser  = out_ovf;

endmodule

// ===== sv/lwfd_checker.sv =====
// port-level checks for the longest-window block, bound to the top level
module lwfd_checker
  import lwfd_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [OUT_DAT_W-1:0] m_tdata,
  input logic                 m_tlast,
  input logic                 m_tuser
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // best length covers the current window and neither is zero
  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2*LEN_W-1:LEN_W] <= m_tdata[LEN_W-1:0]
      && m_tdata[2*LEN_W-1:LEN_W] != '0)
    else $error("window length above best length or zero");

  // best length does not drop across an idle gap between two result beats of a sequence
  a_mono: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast ##1 !m_tvalid ##1 m_tvalid
      |-> m_tdata[LEN_W-1:0] >= $past(m_tdata[LEN_W-1:0], 2))
    else $error("best length fell within a sequence");

  // no result beat is valid straight after reset
  a_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat right after reset");

  // input stage always has room when the result stage drains
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result stage");

endmodule

bind longest_window_few_distinct lwfd_checker u_lwfd_checker (.*);

// ===== tb/longest_window_checker.sv =====
// checker for the longest-window block: tracks the window table, predicts every result beat
module longest_window_checker
  import lwfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [VAL_W-1:0]     s_tdata,
  input  logic                 s_tlast,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [OUT_DAT_W-1:0] m_tdata,
  input  logic                 m_tlast,
  input  logic                 m_tuser,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct packed {
    logic [LEN_W-1:0] best;
    logic [LEN_W-1:0] wlen;
    logic             fin;
    logic             ovf;
  } window_result_t;

  window_result_t   window_results_q[$];

  logic [CFG_W-1:0] kinds_cfg;
  logic [VAL_W-1:0] kind_val  [MAX_KINDS_DEF];
  longint           kind_pos  [MAX_KINDS_DEF];
  bit               kind_busy [MAX_KINDS_DEF];
  longint           win_start;
  longint           seq_pos;
  longint           best_len;
  bit               ovf_flag;

  function automatic void clear_window();
    for (int i = 0; i < MAX_KINDS_DEF; i++) begin
      kind_busy[i] = 1'b0;
      kind_val[i]  = '0;
      kind_pos[i]  = 0;
    end
    win_start = 0;
    seq_pos   = 0;
    best_len  = 1;
    ovf_flag  = 1'b0;
  endfunction

  function automatic window_result_t predict_window(input logic [VAL_W-1:0] v, input logic last);
    window_result_t r;
    longint cur;
    longint wl;
    int     limit;
    int     n_used;
    int     hit;
    int     free_idx;
    int     oldest;
    limit = int'(kinds_cfg);
    if (limit < 1) limit = 1;
    if (limit > MAX_KINDS_DEF) limit = MAX_KINDS_DEF;
    // position saturates one short of the range once the sequence runs long
    if (seq_pos < longint'(SEQ_MAX_DEF)) begin
      cur = seq_pos;
      seq_pos++;
    end else begin
      cur = longint'(SEQ_MAX_DEF) - 1;
      ovf_flag = 1'b1;
    end
    hit = -1;
    free_idx = -1;
    n_used = 0;
    for (int i = 0; i < MAX_KINDS_DEF; i++) begin
      if (kind_busy[i]) begin
        n_used++;
        if (hit < 0 && kind_val[i] == v) hit = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (hit >= 0) begin
      kind_pos[hit] = cur;
    end else if (n_used < limit && free_idx >= 0) begin
      kind_busy[free_idx] = 1'b1;
      kind_val[free_idx]  = v;
      kind_pos[free_idx]  = cur;
    end else begin
      // evict the stalest kind, lowest index on a tie
      oldest = -1;
      for (int i = 0; i < MAX_KINDS_DEF; i++) begin
        if (kind_busy[i] && (oldest < 0 || kind_pos[i] < kind_pos[oldest])) oldest = i;
      end
      if (oldest >= 0) begin
        if (kind_pos[oldest] + 1 > win_start) win_start = kind_pos[oldest] + 1;
        kind_val[oldest] = v;
        kind_pos[oldest] = cur;
      end
    end
    if (win_start > cur) win_start = cur;
    wl = cur - win_start + 1;
    if (wl > best_len) best_len = wl;
    r.best = best_len[LEN_W-1:0];
    r.wlen = wl[LEN_W-1:0];
    r.fin  = last;
    r.ovf  = ovf_flag;
    if (last) clear_window();
    return r;
  endfunction

  function automatic int field_differs(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    window_result_t got;
    window_result_t want;
    int             errs;
    errs = 0;
    if (rst) begin
      window_results_q.delete();
      kinds_cfg = KINDS_RESET;
      clear_window();
      mismatches <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.best = m_tdata[LEN_W-1:0];
        got.wlen = m_tdata[2*LEN_W-1:LEN_W];
        got.fin  = m_tlast;
        got.ovf  = m_tuser;
        if (window_results_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual best %0d window %0d",
                   $time, got.best, got.wlen);
          errs++;
        end else begin
          want = window_results_q.pop_front();
          errs += field_differs("best_length", longint'(want.best), longint'(got.best));
          errs += field_differs("window_length", longint'(want.wlen), longint'(got.wlen));
          errs += field_differs("final_result", longint'(want.fin), longint'(got.fin));
          errs += field_differs("overflow", longint'(want.ovf), longint'(got.ovf));
        end
      end
      if (cfg_valid && cfg_ready) kinds_cfg = cfg_data;
      if (s_tvalid && s_tready) window_results_q.push_back(predict_window(s_tdata, s_tlast));
      mismatches <= mismatches + errs;
    end
    outstanding <= window_results_q.size();
  end

endmodule

// ===== tb/longest_window_few_distinct_tb.sv =====
// top of the longest-window testbench: clock, reset, stimulus and verdict
module longest_window_few_distinct_tb;
  import lwfd_pkg::*;

  // generous ceiling on the run
  localparam int RUN_LIMIT       = 1_000_000;
  // random beats per idling mode, three modes
  localparam int ITEMS_PER_PHASE = 360;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic [VAL_W-1:0]     s_tdata   = '0;
  logic                 s_tlast   = 1'b0;
  logic                 m_tready  = 1'b0;
  logic                 cfg_ready;
  logic                 s_tready;
  logic                 m_tvalid;
  logic [OUT_DAT_W-1:0] m_tdata;
  logic                 m_tlast;
  logic                 m_tuser;

  int mismatches;
  int outstanding;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  longest_window_few_distinct dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),   // kinds_allowed
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [31:0] item_value
    .s_tlast   (s_tlast),    // seq_end
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [16:0] best_length, [33:17] window_length, rest zero
    .m_tlast   (m_tlast),    // final_result
    .m_tuser   (m_tuser)     // overflow
  );

  longest_window_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // receiver backpressure, redrawn every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // watchdog
  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // one input beat; valid stays up into the next beat unless the sender idles
  task automatic send_item(input logic [VAL_W-1:0] v, input logic last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  // stop sending and wait for every predicted result beat to come back
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // register write, only issued while the block has nothing in flight
  task automatic write_kinds(input logic [CFG_W-1:0] k);
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [VAL_W-1:0] pool [6];
    int               pool_n;
    int               seg_len;
    int               sent;
    logic [VAL_W-1:0] v;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part runs under the first idling mode
    tx_idle_pct = 20;
    rx_idle_pct = 85;

    // reset setting of two kinds, all-zero and all-ones values, third kind evicts zero
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h8000_0001, 1'b0);
    send_item(32'h8000_0001, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    // sequence of a single beat
    send_item(32'h5A5A_A5A5, 1'b1);

    // widest table: fill all four, then a fifth kind evicts the stalest
    settle();
    write_kinds(3'd4);
    send_item(32'd1, 1'b0);
    send_item(32'd2, 1'b0);
    send_item(32'd3, 1'b0);
    send_item(32'd4, 1'b0);
    send_item(32'd1, 1'b0);
    send_item(32'd5, 1'b0);

    // limit lowered mid-sequence, table still holds four kinds
    settle();
    write_kinds(3'd1);
    send_item(32'd3, 1'b0);
    send_item(32'd6, 1'b0);
    send_item(32'd6, 1'b1);

    // zero behaves as one
    settle();
    write_kinds(3'd0);
    send_item(32'd7, 1'b0);
    send_item(32'd7, 1'b0);
    send_item(32'd8, 1'b1);

    // top code behaves as four
    settle();
    write_kinds(3'd7);
    send_item(32'd1, 1'b0);
    send_item(32'd2, 1'b0);
    send_item(32'd3, 1'b0);
    send_item(32'd4, 1'b0);
    send_item(32'd5, 1'b1);

    // random part: segments drawing from a small value pool so windows grow,
    // with some noise values and a register change between most segments
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 20;
          rx_idle_pct = 85;
        end
        1: begin
          tx_idle_pct = 85;
          rx_idle_pct = 20;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        settle();
        if ($urandom_range(0, 3) != 0) write_kinds(CFG_W'($urandom_range(0, 7)));
        pool_n = $urandom_range(1, 6);
        for (int i = 0; i < pool_n; i++) begin
          pool[i] = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom_range(0, 3)) : $urandom;
        end
        seg_len = $urandom_range(8, 48);
        for (int i = 0; i < seg_len; i++) begin
          // occasional drift so the mix of kinds changes inside a sequence
          if ($urandom_range(0, 19) == 0) pool[$urandom_range(0, pool_n - 1)] = $urandom;
          v = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
          send_item(v, ($urandom_range(0, 19) == 0));
          sent++;
        end
      end
    end

    // drain, then wait on to catch any stray result beat
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
